>>> hdl/pmpl_pkg.sv
// Shared types, constants and the hex decoder of the port and MAC pair line parser.
package pmpl_pkg;

    localparam int ADDRESS_BYTES_DEF = 6;
    localparam int ADDR_W = 48;
    localparam int PORT_W = 16;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_F  = 8'h66;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_F  = 8'h46;
    localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;
    localparam logic [19:0] PORT_LIMIT = 20'd65535;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_PORT  = 3'd1,
        ST_BAD_DEST  = 3'd2,
        ST_BAD_SRC   = 3'd3,
        ST_TRUNCATED = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        PH_PORT = 5'b00001,
        PH_DEST = 5'b00010,
        PH_SKIP = 5'b00100,
        PH_SRC  = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [PORT_W-1:0] port_number;
        logic [ADDR_W-1:0] dest_address;
        logic [ADDR_W-1:0] source_address;
        t_status           status;
    } t_result;

    // Returns {is_hex, value}; letters of either case map to 10 to 15.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] res;
        res = 5'd0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            res = {1'b1, c[3:0]};
        end else if ((c >= CH_LC_A && c <= CH_LC_F) || (c >= CH_UC_A && c <= CH_UC_F)) begin
            res = {1'b1, c[3:0] + HEX_LETTER_OFFSET};
        end
        return res;
    endfunction

endpackage

>>> hdl/pmpl_if.sv
// Valid/ready channel interfaces for the character input and the parse result output.
interface pmpl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_line;

    modport source (output valid, output char_code, output end_of_line, input ready);
    modport sink (input valid, input char_code, input end_of_line, output ready);
endinterface

interface pmpl_out_if
    import pmpl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [PORT_W-1:0] port_number;
    logic [ADDR_W-1:0] dest_address;
    logic [ADDR_W-1:0] source_address;
    t_status           status;

    modport source (output valid, output port_number, output dest_address,
                    output source_address, output status, input ready);
    modport sink (input valid, input port_number, input dest_address,
                  input source_address, input status, output ready);
endinterface

>>> hdl/port_and_mac_pair_line_parser_core.sv
// Top level of the port and MAC pair line parser: parse state, result register and skid stage.
//
// The block takes one character word per clock cycle and its result for a line is registered
// into the output or skid register by the word that completes the source address, hits the
// first error, or ends the line early. Each word updates the parse state through a
// single stage of logic (port multiply-by-ten, hex decode, byte shift), so the sustained
// rate is one word per cycle. Results leave through an output register backed by a skid
// register; the input is held off only while both of them hold a result that the sink
// has not taken. Characters after a result are dropped until the end-of-line word, which
// always returns the parser to the port field for the next line.
module port_and_mac_pair_line_parser_core
    import pmpl_pkg::*;
#(
    parameter int ADDRESS_BYTES = ADDRESS_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    pmpl_in_if.sink           i_in,
    pmpl_out_if.source        o_out
);

    localparam int LAST_POS = 3 * ADDRESS_BYTES - 2;
    localparam int CIF_W = (LAST_POS + 1 > 1) ? $clog2(LAST_POS + 1) : 1;

    t_phase              r_phase, n_phase;
    logic [CIF_W-1:0]    r_cif, n_cif;
    logic [1:0]          r_sub, n_sub;
    logic [7:0]          r_byte, n_byte;
    logic [PORT_W-1:0]   r_port, n_port;
    logic [ADDR_W-1:0]   r_dest, n_dest;
    logic [ADDR_W-1:0]   r_src, n_src;

    logic                r_out_valid, r_skid_valid;
    t_result             r_out, r_skid;

    logic                in_acc;
    logic                out_free;
    logic                res_valid;
    t_status             res_status;
    t_result             res;
    logic [PORT_W-1:0]   upd_port;
    logic [19:0]         port_x10;
    logic [4:0]          hex;
    logic [ADDR_W-1:0]   mac_shift;
    logic [ADDR_W-1:0]   mac_shift_new;
    logic [7:0]          mac_byte;
    logic                mac_err, mac_done, mac_shift_en, mac_adv;

    assign out_free = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_skid_valid;
    assign in_acc = i_in.valid && i_in.ready;

    assign hex = hex_decode(i_in.char_code);
    assign port_x10 = ({4'd0, r_port} << 3) + ({4'd0, r_port} << 1)
                      + {16'd0, i_in.char_code[3:0]};

    // One MAC field step, shared by the destination and source phases.
    always_comb begin
        mac_shift = (r_phase == PH_SRC) ? r_src : r_dest;
        mac_err = 1'b0;
        mac_done = 1'b0;
        mac_shift_en = 1'b0;
        mac_adv = 1'b0;
        mac_byte = r_byte;
        unique case (r_sub)
            2'd2: begin
                if (i_in.char_code != CH_COLON) begin
                    mac_err = 1'b1;
                end else begin
                    mac_adv = 1'b1;
                end
            end
            2'd0: begin
                if (!hex[4]) begin
                    mac_err = 1'b1;
                end else begin
                    mac_byte = {hex[3:0], 4'd0};
                    mac_adv = 1'b1;
                end
            end
            2'd1: begin
                if (!hex[4]) begin
                    mac_err = 1'b1;
                end else begin
                    mac_byte = r_byte | {4'd0, hex[3:0]};
                    mac_shift_en = 1'b1;
                    if (r_cif == CIF_W'(LAST_POS)) begin
                        mac_done = 1'b1;
                    end else begin
                        mac_adv = 1'b1;
                    end
                end
            end
            default: begin
                mac_err = 1'b1;
            end
        endcase
        mac_shift_new = {mac_shift[ADDR_W-9:0], mac_byte};
    end

    always_comb begin
        n_phase = r_phase;
        n_cif = r_cif;
        n_sub = r_sub;
        n_byte = r_byte;
        n_port = r_port;
        n_dest = r_dest;
        n_src = r_src;
        res_valid = 1'b0;
        res_status = ST_OK;

        if (in_acc) begin
            unique case (r_phase)
                PH_PORT: begin
                    if (i_in.char_code >= CH_ZERO && i_in.char_code <= CH_NINE) begin
                        if (port_x10 > PORT_LIMIT) begin
                            n_port = '1;
                            res_valid = 1'b1;
                            res_status = ST_BAD_PORT;
                        end else begin
                            n_port = port_x10[PORT_W-1:0];
                        end
                    end else if (i_in.char_code == CH_SPACE) begin
                        n_phase = PH_DEST;
                        n_cif = '0;
                        n_sub = 2'd0;
                        n_dest = '0;
                    end else begin
                        res_valid = 1'b1;
                        res_status = ST_BAD_PORT;
                    end
                end
                PH_DEST, PH_SRC: begin
                    n_byte = mac_byte;
                    if (mac_adv) begin
                        n_cif = r_cif + CIF_W'(1);
                        n_sub = (r_sub == 2'd2) ? 2'd0 : r_sub + 2'd1;
                    end
                    if (r_phase == PH_DEST) begin
                        if (mac_shift_en) n_dest = mac_shift_new;
                        if (mac_err) begin
                            res_valid = 1'b1;
                            res_status = ST_BAD_DEST;
                        end else if (mac_done) begin
                            n_phase = PH_SKIP;
                        end
                    end else begin
                        if (mac_shift_en) n_src = mac_shift_new;
                        if (mac_err) begin
                            res_valid = 1'b1;
                            res_status = ST_BAD_SRC;
                        end else if (mac_done) begin
                            res_valid = 1'b1;
                            res_status = ST_OK;
                        end
                    end
                end
                PH_SKIP: begin
                    n_phase = PH_SRC;
                    n_cif = '0;
                    n_sub = 2'd0;
                    n_src = '0;
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_DONE;
                end
            endcase

            if (res_valid) begin
                n_phase = PH_DONE;
            end else if (i_in.end_of_line && n_phase != PH_DONE) begin
                res_valid = 1'b1;
                res_status = ST_TRUNCATED;
            end
        end

        // The result carries the port as it stood before the end of line clears it.
        upd_port = n_port;

        if (in_acc && i_in.end_of_line) begin
            n_phase = PH_PORT;
            n_cif = '0;
            n_sub = 2'd0;
            n_byte = 8'd0;
            n_port = '0;
        end

        res.port_number = upd_port;
        res.dest_address = (res_status == ST_OK) ? n_dest : '0;
        res.source_address = (res_status == ST_OK) ? n_src : '0;
        res.status = res_status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PORT;
            r_cif <= '0;
            r_sub <= 2'd0;
            r_byte <= 8'd0;
            r_port <= '0;
            r_dest <= '0;
            r_src <= '0;
            r_out_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cif <= n_cif;
            r_sub <= n_sub;
            r_byte <= n_byte;
            r_port <= n_port;
            r_dest <= n_dest;
            r_src <= n_src;
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : res;
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.port_number = r_out.port_number;
    assign o_out.dest_address = r_out.dest_address;
    assign o_out.source_address = r_out.source_address;
    assign o_out.status = r_out.status;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register holds a result while the output register is empty");

    a_err_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != ST_OK)
            |-> (r_out.dest_address == '0 && r_out.source_address == '0))
        else $error("error result carries a non-zero address");

    a_eol_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.end_of_line) |=> (r_phase == PH_PORT && r_port == '0))
        else $error("end of line did not return the parser to the port field");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cif <= CIF_W'(LAST_POS)) && (r_sub != 2'd3))
        else $error("MAC character position out of range");

endmodule
